// ===== design/ash_fd_pkg.sv =====
package ash_fd_pkg;

  // field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CAP_W   = 9;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned LEN_W   = 9;
  localparam int unsigned CRC_W   = 16;

  // default frame storage size
  localparam int unsigned MAX_FRAME_BYTES_DEF = 256;

  // reset value of the capacity register
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  // link control characters
  localparam logic [BYTE_W-1:0] CH_FLAG   = 8'h7E;
  localparam logic [BYTE_W-1:0] CH_ESC    = 8'h7D;
  localparam logic [BYTE_W-1:0] CH_XON    = 8'h11;
  localparam logic [BYTE_W-1:0] CH_XOFF   = 8'h13;
  localparam logic [BYTE_W-1:0] CH_SUB    = 8'h18;
  localparam logic [BYTE_W-1:0] CH_CAN    = 8'h1A;
  localparam logic [BYTE_W-1:0] STUFF_BIT = 8'h20;

  // crc-ccitt
  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_MSB  = 16'h8000;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_DATA    = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_DISCARD = 2'd2
  } kind_e;

  // channel payloads
  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic [CAP_W-1:0] frame_capacity;
  } cfg_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  result_kind;
    logic [BYTE_W-1:0]  data_byte;
    logic [INDEX_W-1:0] byte_index;
    logic [LEN_W-1:0]   frame_length;
  } result_t;

  // one byte of crc-ccitt, msb first
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != '0) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== design/ash_fd_stream_if.sv =====
interface ash_fd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/ash_fd_core.sv =====
module ash_fd_core #(
  parameter int unsigned MAX_FRAME_BYTES = ash_fd_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic [ash_fd_pkg::BYTE_W-1:0]   byte_i,
  input  logic [ash_fd_pkg::CAP_W-1:0]    cap_i,
  output logic                            res_valid_o,
  output ash_fd_pkg::result_t             res_o
);
  import ash_fd_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned WIDE_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // frame state
  logic [CNT_W-1:0] byte_count_q, byte_count_d;
  logic             escape_q, escape_d;
  logic             bad_q, bad_d;
  logic [CRC_W-1:0] crc_q, crc_d;

  logic [WIDE_W-1:0]  cnt_wide;
  logic [WIDE_W-1:0]  cap_wide;
  logic [WIDE_W-1:0]  cap_eff;
  logic [BYTE_W-1:0]  db;
  logic               frame_ok;

  // effective capacity saturates at the storage size
  assign cnt_wide = WIDE_W'(byte_count_q);
  assign cap_wide = WIDE_W'(cap_i);
  assign cap_eff  = (cap_wide > WIDE_W'(MAX_FRAME_BYTES)) ? WIDE_W'(MAX_FRAME_BYTES)
                                                           : cap_wide;
  assign db       = escape_q ? (byte_i ^ STUFF_BIT) : byte_i;
  assign frame_ok = !bad_q && (cnt_wide >= WIDE_W'(3)) && (crc_q == '0);

  // byte decode and frame state update
  always_comb begin
    byte_count_d = byte_count_q;
    escape_d     = escape_q;
    bad_d        = bad_q;
    crc_d        = crc_q;
    res_valid_o  = 1'b0;
    res_o        = '0;
    if (byte_i == CH_CAN) begin
      byte_count_d       = '0;
      escape_d           = 1'b0;
      bad_d              = 1'b0;
      crc_d              = CRC_INIT;
      res_valid_o        = 1'b1;
      res_o.result_kind  = KIND_DISCARD;
    end else if (byte_i inside {CH_XON, CH_XOFF}) begin
      // flow control bytes are dropped
    end else if (byte_i == CH_SUB) begin
      bad_d = 1'b1;
    end else if (byte_i == CH_FLAG) begin
      byte_count_d = '0;
      escape_d     = 1'b0;
      bad_d        = 1'b0;
      crc_d        = CRC_INIT;
      res_valid_o  = 1'b1;
      if (frame_ok) begin
        res_o.result_kind  = KIND_ACCEPT;
        res_o.frame_length = cnt_wide[LEN_W-1:0];
      end else begin
        res_o.result_kind  = KIND_DISCARD;
      end
    end else if (byte_i == CH_ESC) begin
      escape_d = 1'b1;
    end else begin
      escape_d = 1'b0;
      if (cnt_wide < cap_eff) begin
        crc_d             = crc_byte(crc_q, db);
        byte_count_d      = byte_count_q + CNT_W'(1);
        res_valid_o       = 1'b1;
        res_o.result_kind = KIND_DATA;
        res_o.data_byte   = db;
        res_o.byte_index  = cnt_wide[INDEX_W-1:0];
      end else begin
        // overflow drops the byte and spoils the frame
        bad_d = 1'b1;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      escape_q     <= 1'b0;
      bad_q        <= 1'b0;
      crc_q        <= CRC_INIT;
    end else if (step_i) begin
      byte_count_q <= byte_count_d;
      escape_q     <= escape_d;
      bad_q        <= bad_d;
      crc_q        <= crc_d;
    end
  end

endmodule

// ===== design/ash_frame_deframer_unit.sv =====
// Receive-side deframer for an ASH-style serial link. Raw link bytes enter on
// rx_i one per transaction; de-stuffed frame bytes, frame accepts and discards
// leave on res_o. Flow-control bytes, escapes, substitutes and bytes beyond the
// capacity give no result. One byte is taken every clock cycle when res_o is
// not stalled; a byte lands in the input register, then the byte-wide CRC-CCITT
// step and decode feed the result register, which offers the result. The user
// must write the frame capacity register on cfg_i only while the block is idle;
// the block does not enforce it. Effective capacity is limited to MAX_FRAME_BYTES.
module ash_frame_deframer_unit #(
  parameter int unsigned MAX_FRAME_BYTES = ash_fd_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  ash_fd_stream_if.sink   rx_i,
  ash_fd_stream_if.sink   cfg_i,
  ash_fd_stream_if.source res_o
);
  import ash_fd_pkg::*;

  logic [CAP_W-1:0]  cap_q;
  logic              in_valid_q;
  logic [BYTE_W-1:0] in_byte_q;
  logic              out_valid_q;
  result_t           out_q;

  logic              advance;
  logic              in_ready;
  logic              step;
  logic              core_valid;
  result_t           core_res;

  // pipeline handshake
  assign advance     = !out_valid_q || res_o.ready;
  assign in_ready    = !in_valid_q || advance;
  assign step        = in_valid_q && advance;
  assign rx_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_i.valid) begin
      cap_q <= cfg_i.payload.frame_capacity;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && rx_i.valid) begin
      in_byte_q <= rx_i.payload.rx_byte;
    end
  end

  ash_fd_core #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .cap_i       (cap_q),
    .res_valid_o (core_valid),
    .res_o       (core_res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && core_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && core_valid) begin
      out_q <= core_res;
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import ash_fd_pkg::*;

  localparam int unsigned FRAME_LIMIT  = MAX_FRAME_BYTES_DEF;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          LONG_HOLD     = 300;
  localparam int          CYCLE_LIMIT   = 200000;
  localparam int          REPORT_MAX    = 10;

  logic clk_i;
  logic rst_ni;

  ash_fd_stream_if #(.payload_t(rx_item_t))  rx_if ();
  ash_fd_stream_if #(.payload_t(cfg_item_t)) cfg_if ();
  ash_fd_stream_if #(.payload_t(result_t))   res_if ();

  ash_frame_deframer_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  // shadow state of the deframer
  logic [CAP_W-1:0] capacity_q;
  logic [8:0]       frame_cnt;
  logic             esc_pending;
  logic             frame_bad;
  logic [CRC_W-1:0] frame_crc;

  logic [BYTE_W-1:0] rx_pending[$];
  result_t           link_events_q[$];

  int mismatch_cnt;
  int cycle_cnt;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_req_cnt;
  int hold_seen;
  int hold_left;

  // clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // crc-ccitt, one bit at a time, msb first
  function automatic logic [CRC_W-1:0] crc_ccitt_step(input logic [CRC_W-1:0] c,
                                                     input logic [BYTE_W-1:0] d);
    logic fb;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      fb = c[CRC_W-1] ^ d[i];
      c  = {c[CRC_W-2:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic bit is_link_ctrl(input logic [BYTE_W-1:0] b);
    return (b == CH_FLAG) || (b == CH_ESC) || (b == CH_XON) || (b == CH_XOFF) ||
           (b == CH_SUB) || (b == CH_CAN);
  endfunction

  function automatic void clear_frame_state();
    frame_cnt   = '0;
    esc_pending = 1'b0;
    frame_bad   = 1'b0;
    frame_crc   = CRC_INIT;
  endfunction

  // predicted outcome of one raw link byte
  function automatic void deframe_byte(input logic [BYTE_W-1:0] raw);
    logic [BYTE_W-1:0] b;
    logic [8:0]        lim;
    result_t           r;
    b   = raw;
    lim = (capacity_q > FRAME_LIMIT) ? 9'(FRAME_LIMIT) : capacity_q;
    r   = '0;
    if (b == CH_CAN) begin
      clear_frame_state();
      r.result_kind = KIND_DISCARD;
      link_events_q.push_back(r);
    end else if (b == CH_XON || b == CH_XOFF) begin
      // flow control is dropped
    end else if (b == CH_SUB) begin
      frame_bad = 1'b1;
    end else if (b == CH_FLAG) begin
      if (!frame_bad && frame_cnt >= 3 && frame_crc == '0) begin
        r.result_kind  = KIND_ACCEPT;
        r.frame_length = frame_cnt;
      end else begin
        r.result_kind = KIND_DISCARD;
      end
      clear_frame_state();
      link_events_q.push_back(r);
    end else if (b == CH_ESC) begin
      esc_pending = 1'b1;
    end else begin
      if (esc_pending) begin
        b           = b ^ STUFF_BIT;
        esc_pending = 1'b0;
      end
      if (frame_cnt < lim) begin
        r.result_kind = KIND_DATA;
        r.data_byte   = b;
        r.byte_index  = frame_cnt[INDEX_W-1:0];
        frame_crc     = crc_ccitt_step(frame_crc, b);
        frame_cnt     = frame_cnt + 1'b1;
        link_events_q.push_back(r);
      end else begin
        frame_bad = 1'b1;
      end
    end
  endfunction

  // rx driver: predicts each accepted byte, then offers the next pending one
  always @(posedge clk_i) begin : drive_rx
    if (rst_ni) begin
      if (rx_if.valid && rx_if.ready) begin
        deframe_byte(rx_if.payload.rx_byte);
      end
      if (!rx_if.valid || rx_if.ready) begin
        if (rx_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          rx_if.valid   <= 1'b1;
          rx_if.payload <= rx_item_t'(rx_pending.pop_front());
        end else begin
          rx_if.valid <= 1'b0;
        end
      end
    end
  end

  // result ready, with random stalls and an occasional long hold
  always @(posedge clk_i) begin : drive_res_ready
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (hold_req_cnt != hold_seen) begin
        hold_seen = hold_req_cnt;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic flag_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_MAX) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      flag_mismatch($sformatf("%s expected %0h got %0h", name, want, got));
    end
  endtask

  // result monitor
  always @(posedge clk_i) begin : check_results
    result_t want;
    result_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = res_if.payload;
      if (link_events_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result kind %0d data %0h index %0d length %0d",
                                got.result_kind, got.data_byte, got.byte_index,
                                got.frame_length));
      end else begin
        want = link_events_q.pop_front();
        check_field("result_kind", want.result_kind, got.result_kind);
        check_field("data_byte", want.data_byte, got.data_byte);
        check_field("byte_index", want.byte_index, got.byte_index);
        check_field("frame_length", want.frame_length, got.frame_length);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // stimulus helpers
  function automatic logic [BYTE_W-1:0] rand_link_byte();
    logic [BYTE_W-1:0] ctrl[6];
    ctrl = '{CH_FLAG, CH_ESC, CH_XON, CH_XOFF, CH_SUB, CH_CAN};
    if ($urandom_range(3) == 0) begin
      return ctrl[$urandom_range(5)];
    end
    return BYTE_W'($urandom_range(255));
  endfunction

  function automatic void queue_flow_ctrl();
    rx_pending.push_back(($urandom_range(1) != 0) ? CH_XON : CH_XOFF);
  endfunction

  // one frame byte as it goes on the wire, escaped where needed and at random otherwise
  function automatic void queue_stuffed(input logic [BYTE_W-1:0] b, input bit noisy);
    if (noisy && $urandom_range(19) == 0) begin
      queue_flow_ctrl();
    end
    if (is_link_ctrl(b) ||
        (!is_link_ctrl(b ^ STUFF_BIT) && $urandom_range(15) == 0)) begin
      rx_pending.push_back(CH_ESC);
      if (noisy && $urandom_range(7) == 0) begin
        queue_flow_ctrl();
      end
      rx_pending.push_back(b ^ STUFF_BIT);
    end else begin
      rx_pending.push_back(b);
    end
  endfunction

  // payload plus crc, optionally corrupted or substituted, closed by a flag
  function automatic void queue_frame(input int n, input bit corrupt, input bit add_sub,
                                      input bit noisy);
    logic [BYTE_W-1:0] body[$];
    logic [CRC_W-1:0]  c;
    logic [BYTE_W-1:0] b;
    int                k;
    c = CRC_INIT;
    for (int i = 0; i < n; i++) begin
      b = rand_link_byte();
      body.push_back(b);
      c = crc_ccitt_step(c, b);
    end
    body.push_back(c[15:8]);
    body.push_back(c[7:0]);
    if (corrupt) begin
      k = $urandom_range(body.size() - 1);
      body[k] = body[k] ^ (8'h01 << $urandom_range(7));
    end
    foreach (body[i]) begin
      queue_stuffed(body[i], noisy);
      if (add_sub && i == body.size() / 2) begin
        rx_pending.push_back(CH_SUB);
      end
    end
    rx_pending.push_back(CH_FLAG);
  endfunction

  function automatic void queue_directed();
    rx_pending.push_back(CH_FLAG);
    rx_pending.push_back(CH_CAN);
    rx_pending.push_back(8'h00);
    rx_pending.push_back(8'hFF);
    rx_pending.push_back(CH_XON);
    rx_pending.push_back(CH_XOFF);
    // escape held across flow control
    rx_pending.push_back(CH_ESC);
    rx_pending.push_back(CH_XON);
    rx_pending.push_back(8'h5E);
    // repeated escape
    rx_pending.push_back(CH_ESC);
    rx_pending.push_back(CH_ESC);
    rx_pending.push_back(8'h5D);
    // substitute spoils the frame but bytes still count
    rx_pending.push_back(CH_SUB);
    rx_pending.push_back(8'h01);
    rx_pending.push_back(CH_FLAG);
    // escape followed by flag or cancel acts as the control byte
    rx_pending.push_back(CH_ESC);
    rx_pending.push_back(CH_FLAG);
    rx_pending.push_back(CH_ESC);
    rx_pending.push_back(CH_CAN);
    // shortest good frame
    queue_frame(1, 1'b0, 1'b0, 1'b0);
  endfunction

  function automatic void queue_random_traffic(input int target, input bit big);
    int start;
    int sel;
    int n;
    start = rx_pending.size();
    if (big) begin
      // frame that fills the storage exactly
      queue_frame(FRAME_LIMIT - 2, 1'b0, 1'b0, 1'b0);
    end
    while (rx_pending.size() - start < target) begin
      sel = $urandom_range(99);
      if (sel < 60) begin
        queue_frame($urandom_range(1, 12), 1'b0, 1'b0, 1'b1);
      end else if (sel < 70) begin
        queue_frame($urandom_range(1, 12), 1'b1, 1'b0, 1'b1);
      end else if (sel < 75) begin
        queue_frame($urandom_range(1, 8), 1'b0, 1'b1, 1'b1);
      end else if (sel < 80) begin
        // partial frame then cancel
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
          queue_stuffed(BYTE_W'($urandom_range(255)), 1'b1);
        end
        rx_pending.push_back(CH_CAN);
      end else if (sel < 85) begin
        // short frame
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++) begin
          queue_stuffed(BYTE_W'($urandom_range(255)), 1'b0);
        end
        rx_pending.push_back(CH_FLAG);
      end else if (sel < 90) begin
        rx_pending.push_back(CH_FLAG);
        rx_pending.push_back(CH_FLAG);
      end else begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          rx_pending.push_back(rand_link_byte());
        end
      end
    end
  endfunction

  task automatic wait_drained();
    while (rx_pending.size() != 0 || rx_if.valid || link_events_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    @(posedge clk_i);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= cfg_item_t'(v);
    do @(posedge clk_i); while (!cfg_if.ready);
    capacity_q = v;
    cfg_if.valid <= 1'b0;
  endtask

  // main sequence
  initial begin : main_seq
    logic [CAP_W-1:0] phase_caps[8];
    rx_if.valid    = 1'b0;
    rx_if.payload  = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;
    res_if.ready   = 1'b0;
    rst_ni         = 1'b0;
    mismatch_cnt   = 0;
    cycle_cnt      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req_cnt   = 0;
    hold_seen      = 0;
    hold_left      = 0;
    capacity_q     = CAP_RESET;
    clear_frame_state();

    phase_caps = '{CAP_RESET, 9'd3, 9'd511, 9'd0, 9'($urandom_range(4, 40)), 9'd2,
                   9'($urandom_range(3, 255)), 9'd256};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 67;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 67;
        end
        default: begin
          send_idle_pct  = 6;
          recv_stall_pct = 6;
        end
      endcase
      if (p == 0) begin
        queue_directed();
      end else begin
        write_capacity(phase_caps[p]);
      end
      // long receiver hold while bytes keep coming
      if (p == 2) begin
        hold_req_cnt++;
      end
      queue_random_traffic(20, (p == 7));
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && link_events_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/ash_fd_pkg.sv
design/ash_fd_stream_if.sv
design/ash_fd_core.sv
design/ash_frame_deframer_unit.sv
tb/sv/tb_top.sv
